[rtl/krs_pkg.sv]
// keyed record stack: shared constants, operation and status codes
// no dependencies; imported by the top level and the testbench
`timescale 1ns / 1ps

package krs_pkg;

	// store geometry
	localparam int DEPTH  = 64;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// item field widths
	localparam int OP_W   = 3;
	localparam int KEY_W  = 16;
	localparam int PAY_W  = 32;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 7;
	localparam int REC_W  = KEY_W + PAY_W;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
	localparam logic [OP_W-1:0] OP_POP    = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
	localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
	localparam logic [OP_W-1:0] OP_UPDATE = 3'd4;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd5;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

[rtl/keyed_record_stack.sv]
// keyed record stack: top level with sequencer and shared key comparator
// depends on krs_pkg and krs_ram
`timescale 1ns / 1ps

// A last-in-first-out store of up to DEPTH records (16-bit key, 32-bit
// payload). An item is taken when start is high and busy is low; its single
// result appears on status, found_key, found_payload and occupancy for one
// cycle while done is high, and must be captured then, as the next item
// overwrites it. Push, any unused operation code, and pop or peek on an empty
// store answer in the cycle after the item is taken, with busy staying
// low. Pop and peek on a non-empty store answer after the S_TOP state,
// for the ram read. Search, update and delete walk the stored records
// through the one ram read port and one key comparator, one record per
// cycle, with busy high until they answer; search ends early at the
// first hit from the top. Delete compacts in place through the ram write
// port during the same walk. No clearing pass is needed at reset.

module keyed_record_stack
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [krs_pkg::OP_W-1:0]   operation,
	input  logic [krs_pkg::KEY_W-1:0]  record_key,
	input  logic [krs_pkg::PAY_W-1:0]  record_payload,
	output logic                       done,
	output logic [krs_pkg::STAT_W-1:0] status,
	output logic [krs_pkg::KEY_W-1:0]  found_key,
	output logic [krs_pkg::PAY_W-1:0]  found_payload,
	output logic [krs_pkg::OCC_W-1:0]  occupancy
);

	import krs_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_TOP,
		S_SCAN
	} state_t;

	state_t              state_q;
	logic [OP_W-1:0]     op_q;
	logic [KEY_W-1:0]    key_q;
	logic [PAY_W-1:0]    payload_q;
	logic [CNT_W-1:0]    count_q;
	logic [ADDR_W-1:0]   iss_idx_q;
	logic [CNT_W-1:0]    iss_left_q;
	logic                chk_vld_s1;
	logic [ADDR_W-1:0]   chk_idx_s1;
	logic [CNT_W-1:0]    wr_ptr_q;
	logic                hit_q;
	logic                done_q;
	logic [STAT_W-1:0]   status_q;
	logic [KEY_W-1:0]    found_key_q;
	logic [PAY_W-1:0]    found_payload_q;
	logic [OCC_W-1:0]    occupancy_q;

	logic                ram_wr_en;
	logic [ADDR_W-1:0]   ram_wr_addr;
	logic [REC_W-1:0]    ram_wr_data;
	logic [ADDR_W-1:0]   ram_rd_addr;
	logic [REC_W-1:0]    ram_rd_data;
	logic [KEY_W-1:0]    rd_key;
	logic [PAY_W-1:0]    rd_payload;
	logic                key_match;
	logic                is_full;
	logic                is_empty;

	assign rd_key     = ram_rd_data[REC_W-1:PAY_W];
	assign rd_payload = ram_rd_data[PAY_W-1:0];
	assign key_match  = (rd_key == key_q);
	assign is_full    = (count_q >= CNT_W'(DEPTH));
	assign is_empty   = (count_q == '0);

	// record store: key in the upper bits, payload below
	krs_ram #(
		.WIDTH (REC_W),
		.DEPTH (DEPTH),
		.AW    (ADDR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// ram port steering
	always_comb begin
		ram_rd_addr = iss_idx_q;
		ram_wr_en   = 1'b0;
		ram_wr_addr = chk_idx_s1;
		ram_wr_data = {rd_key, payload_q};
		unique case (state_q)
			S_IDLE: begin
				ram_rd_addr = ADDR_W'(count_q - 1'b1);
				if (start && (operation == OP_PUSH) && !is_full) begin
					ram_wr_en   = 1'b1;
					ram_wr_addr = ADDR_W'(count_q);
					ram_wr_data = {record_key, record_payload};
				end
			end
			S_SCAN: begin
				if (chk_vld_s1) begin
					if ((op_q == OP_UPDATE) && key_match) begin
						ram_wr_en   = 1'b1;
						ram_wr_addr = chk_idx_s1;
						ram_wr_data = {rd_key, payload_q};
					end else if ((op_q == OP_DELETE) && !key_match) begin
						ram_wr_en   = 1'b1;
						ram_wr_addr = ADDR_W'(wr_ptr_q);
						ram_wr_data = ram_rd_data;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer, entry count and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			op_q            <= '0;
			key_q           <= '0;
			payload_q       <= '0;
			count_q         <= '0;
			iss_idx_q       <= '0;
			iss_left_q      <= '0;
			chk_vld_s1      <= 1'b0;
			chk_idx_s1      <= '0;
			wr_ptr_q        <= '0;
			hit_q           <= 1'b0;
			done_q          <= 1'b0;
			status_q        <= ST_OK;
			found_key_q     <= '0;
			found_payload_q <= '0;
			occupancy_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q            <= operation;
						key_q           <= record_key;
						payload_q       <= record_payload;
						found_key_q     <= '0;
						found_payload_q <= '0;
						occupancy_q     <= OCC_W'(count_q);
						unique case (operation)
							OP_PUSH: begin
								done_q <= 1'b1;
								if (is_full) begin
									status_q <= ST_FULL;
								end else begin
									status_q    <= ST_OK;
									count_q     <= count_q + 1'b1;
									occupancy_q <= OCC_W'(count_q + 1'b1);
								end
							end
							OP_POP, OP_PEEK: begin
								if (is_empty) begin
									done_q   <= 1'b1;
									status_q <= ST_EMPTY;
								end else begin
									state_q <= S_TOP;
								end
							end
							OP_SEARCH, OP_UPDATE, OP_DELETE: begin
								state_q    <= S_SCAN;
								iss_left_q <= count_q;
								iss_idx_q  <= (operation == OP_SEARCH) ?
								              ADDR_W'(count_q - 1'b1) : '0;
								chk_vld_s1 <= 1'b0;
								wr_ptr_q   <= '0;
								hit_q      <= 1'b0;
							end
							default: begin
								done_q   <= 1'b1;
								status_q <= ST_OK;
							end
						endcase
					end
				end
				S_TOP: begin
					// top record is on the read port now
					done_q          <= 1'b1;
					status_q        <= ST_OK;
					found_key_q     <= rd_key;
					found_payload_q <= rd_payload;
					if (op_q == OP_POP) begin
						count_q     <= count_q - 1'b1;
						occupancy_q <= OCC_W'(count_q - 1'b1);
					end
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					// issue the next read, check the one that came back
					if (iss_left_q != '0) begin
						chk_vld_s1 <= 1'b1;
						chk_idx_s1 <= iss_idx_q;
						iss_left_q <= iss_left_q - 1'b1;
						iss_idx_q  <= (op_q == OP_SEARCH) ? iss_idx_q - 1'b1 :
						              iss_idx_q + 1'b1;
					end else begin
						chk_vld_s1 <= 1'b0;
					end
					if (chk_vld_s1) begin
						if (key_match) begin
							hit_q <= 1'b1;
						end else if (op_q == OP_DELETE) begin
							wr_ptr_q <= wr_ptr_q + 1'b1;
						end
					end
					priority if ((op_q == OP_SEARCH) && chk_vld_s1 && key_match) begin
						// topmost hit ends the search early
						done_q          <= 1'b1;
						status_q        <= ST_OK;
						found_key_q     <= rd_key;
						found_payload_q <= rd_payload;
						state_q         <= S_IDLE;
					end else if ((iss_left_q == '0) && !chk_vld_s1) begin
						done_q   <= 1'b1;
						status_q <= hit_q ? ST_OK : ST_NOTFOUND;
						if (op_q == OP_DELETE) begin
							count_q     <= wr_ptr_q;
							occupancy_q <= OCC_W'(wr_ptr_q);
						end
						state_q <= S_IDLE;
					end else begin
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign found_key     = found_key_q;
	assign found_payload = found_payload_q;
	assign occupancy     = occupancy_q;

endmodule

[rtl/krs_ram.sv]
// keyed record stack: generic simple dual-port ram, registered read
// no dependencies; one write port and one read port
`timescale 1ns / 1ps

module krs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[tb/sv/testbench.sv]
// keyed record stack testbench: directed table then random push/pop/search/update/delete traffic
// depends on krs_pkg and keyed_record_stack; results checked against shadow stack or typed rows
`timescale 1ns / 1ps

module testbench;

	import krs_pkg::*;

	// codes that the block ignores
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	localparam int RANDOM_ITEMS = 1050;
	localparam int QUIET_TAIL   = 150;
	localparam int SETTLE_CYCLES = DEPTH + 8;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [STAT_W-1:0] stat;
		logic [KEY_W-1:0]  key;
		logic [PAY_W-1:0]  pay;
		logic [OCC_W-1:0]  occ;
	} outcome_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] pay;
		logic             typed;
		outcome_t         res;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [OP_W-1:0]   operation;
	logic [KEY_W-1:0]  record_key;
	logic [PAY_W-1:0]  record_payload;
	logic              done;
	logic [STAT_W-1:0] status;
	logic [KEY_W-1:0]  found_key;
	logic [PAY_W-1:0]  found_payload;
	logic [OCC_W-1:0]  occupancy;

	// expectation typed into the table, travelling alongside the item
	logic     typed_row;
	outcome_t typed_outcome;

	// shadow copy of the stack
	logic [KEY_W-1:0] shadow_keys [DEPTH];
	logic [PAY_W-1:0] shadow_pays [DEPTH];
	int               shadow_held = 0;

	outcome_t   awaited_outcomes [$];
	stim_row_t  directed_rows [$];
	logic [KEY_W-1:0] segment_keys [8];

	int accepted_items = 0;
	int results_checked = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int full_count = 0;
	int empty_count = 0;
	int miss_count = 0;

	keyed_record_stack dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.record_key     (record_key),
		.record_payload (record_payload),
		.done           (done),
		.status         (status),
		.found_key      (found_key),
		.found_payload  (found_payload),
		.occupancy      (occupancy)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				awaited_outcomes.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// apply one item to the shadow stack and work out its result
	function automatic outcome_t stack_outcome(input logic [OP_W-1:0] op,
		input logic [KEY_W-1:0] key, input logic [PAY_W-1:0] pay);
		outcome_t r;
		bit       hit;
		int       i;
		int       w;
		r = '0;
		hit = 1'b0;
		w = 0;
		case (op)
			OP_PUSH: begin
				if (shadow_held >= DEPTH) begin
					r.stat = ST_FULL;
				end else begin
					shadow_keys[shadow_held] = key;
					shadow_pays[shadow_held] = pay;
					shadow_held++;
				end
			end
			OP_POP, OP_PEEK: begin
				if (shadow_held == 0) begin
					r.stat = ST_EMPTY;
				end else begin
					r.key = shadow_keys[shadow_held - 1];
					r.pay = shadow_pays[shadow_held - 1];
					if (op == OP_POP)
						shadow_held--;
				end
			end
			OP_SEARCH: begin
				// topmost match wins
				for (i = shadow_held - 1; i >= 0; i--) begin
					if (!hit && shadow_keys[i] == key) begin
						hit = 1'b1;
						r.key = shadow_keys[i];
						r.pay = shadow_pays[i];
					end
				end
				if (!hit)
					r.stat = ST_NOTFOUND;
			end
			OP_UPDATE: begin
				for (i = 0; i < shadow_held; i++) begin
					if (shadow_keys[i] == key) begin
						shadow_pays[i] = pay;
						hit = 1'b1;
					end
				end
				if (!hit)
					r.stat = ST_NOTFOUND;
			end
			OP_DELETE: begin
				// compact the survivors downwards, order kept
				for (i = 0; i < shadow_held; i++) begin
					if (shadow_keys[i] == key) begin
						hit = 1'b1;
					end else begin
						shadow_keys[w] = shadow_keys[i];
						shadow_pays[w] = shadow_pays[i];
						w++;
					end
				end
				shadow_held = w;
				if (!hit)
					r.stat = ST_NOTFOUND;
			end
			default: begin
			end
		endcase
		r.occ = OCC_W'(shadow_held);
		return r;
	endfunction

	task automatic note_mismatch(input string what, input outcome_t want, input outcome_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("cycle %0d %s: expected st=%0d key=%h pay=%h occ=%0d, got st=%0d key=%h pay=%h occ=%0d",
				cycle_count, what, want.stat, want.key, want.pay, want.occ,
				got.stat, got.key, got.pay, got.occ);
	endtask

	// result checking and item capture, both at the rising edge
	always @(posedge clk) begin : observe
		outcome_t got;
		outcome_t want;
		outcome_t predicted;
		if (arst_n) begin
			if (done) begin
				got = {status, found_key, found_payload, occupancy};
				if (awaited_outcomes.size() == 0) begin
					note_mismatch("result with no item outstanding", '0, got);
				end else begin
					want = awaited_outcomes.pop_front();
					results_checked++;
					if (got.stat !== want.stat || got.key !== want.key ||
						got.pay !== want.pay || got.occ !== want.occ)
						note_mismatch("wrong result", want, got);
				end
			end
			if (start && !busy) begin
				predicted = stack_outcome(operation, record_key, record_payload);
				want = typed_row ? typed_outcome : predicted;
				awaited_outcomes.push_back(want);
				accepted_items++;
				case (want.stat)
					ST_FULL:     full_count++;
					ST_EMPTY:    empty_count++;
					ST_NOTFOUND: miss_count++;
					default: begin
					end
				endcase
			end
		end
	end

	function automatic void add_row(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
		input logic [PAY_W-1:0] pay, input logic typed, input logic [STAT_W-1:0] st,
		input logic [KEY_W-1:0] k, input logic [PAY_W-1:0] p, input logic [OCC_W-1:0] occ);
		stim_row_t row;
		row.op = op;
		row.key = key;
		row.pay = pay;
		row.typed = typed;
		row.res = {st, k, p, occ};
		directed_rows.push_back(row);
	endfunction

	// present one item and hold it until it is taken
	task automatic send_item(input stim_row_t row);
		int seen;
		seen = accepted_items;
		start <= 1'b1;
		operation <= row.op;
		record_key <= row.key;
		record_payload <= row.pay;
		typed_row <= row.typed;
		typed_outcome <= row.res;
		do @(negedge clk); while (accepted_items == seen);
	endtask

	task automatic pause_sender(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// hold off until every result is in
	task automatic wait_for_results();
		start <= 1'b0;
		do @(negedge clk); while (awaited_outcomes.size() != 0);
	endtask

	// mostly keys from a small per-segment pool so that searches hit and deletes bite
	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return segment_keys[$urandom_range(0, 7)];
		if (r == 7)
			return ($urandom_range(0, 1) != 0) ? '1 : '0;
		return KEY_W'($urandom);
	endfunction

	function automatic logic [PAY_W-1:0] pick_payload();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return PAY_W'($urandom);
		endcase
	endfunction

	function automatic logic [OP_W-1:0] pick_operation(input int kind);
		int r;
		r = $urandom_range(0, 99);
		// fill segments push, drain segments pop and peek
		if (kind < 2)
			return OP_PUSH;
		if (kind == 2)
			return (r < 75) ? OP_POP : OP_PEEK;
		if (r < 35)
			return OP_PUSH;
		if (r < 50)
			return OP_POP;
		if (r < 60)
			return OP_PEEK;
		if (r < 75)
			return OP_SEARCH;
		if (r < 85)
			return OP_UPDATE;
		if (r < 95)
			return OP_DELETE;
		return (r < 97) ? OP_SPARE_LO : OP_SPARE_HI;
	endfunction

	// stimulus
	initial begin
		stim_row_t row;
		int        random_sent;
		int        kind;
		int        seg_len;
		int        n;
		bit        gappy;
		random_sent = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		operation <= OP_PUSH;
		record_key <= '0;
		record_payload <= '0;
		typed_row <= 1'b0;
		typed_outcome <= '0;

		// directed table: empty store, ignored codes, extremes, then predicted rows
		add_row(OP_POP,      16'h1234, 32'h0,        1, ST_EMPTY,    '0, '0, 0);
		add_row(OP_PEEK,     16'h1234, 32'h0,        1, ST_EMPTY,    '0, '0, 0);
		add_row(OP_SEARCH,   16'h1234, 32'h0,        1, ST_NOTFOUND, '0, '0, 0);
		add_row(OP_UPDATE,   16'h1234, 32'h89AB,     1, ST_NOTFOUND, '0, '0, 0);
		add_row(OP_DELETE,   16'h1234, 32'h0,        1, ST_NOTFOUND, '0, '0, 0);
		add_row(OP_SPARE_LO, 16'hFFFF, 32'hFFFFFFFF, 1, ST_OK,       '0, '0, 0);
		add_row(OP_SPARE_HI, 16'hFFFF, 32'hFFFFFFFF, 1, ST_OK,       '0, '0, 0);
		add_row(OP_PUSH,     16'h0000, 32'h0,        1, ST_OK,       '0, '0, 1);
		add_row(OP_PUSH,     16'hFFFF, 32'hFFFFFFFF, 1, ST_OK,       '0, '0, 2);
		add_row(OP_PEEK,     16'h0,    32'h0,        1, ST_OK,       '1, '1, 2);
		add_row(OP_SEARCH,   16'h0000, 32'h0,        1, ST_OK,       '0, '0, 2);
		add_row(OP_PUSH,     16'h00A5, 32'hDEADBEEF, 0, ST_OK,       '0, '0, 0);
		add_row(OP_PUSH,     16'hFFFF, 32'h00000001, 0, ST_OK,       '0, '0, 0);
		add_row(OP_SEARCH,   16'hFFFF, 32'h0,        0, ST_OK,       '0, '0, 0);
		add_row(OP_UPDATE,   16'hFFFF, 32'h5555AAAA, 0, ST_OK,       '0, '0, 0);
		add_row(OP_SEARCH,   16'hFFFF, 32'h0,        0, ST_OK,       '0, '0, 0);
		add_row(OP_SPARE_LO, 16'h00A5, 32'h0,        0, ST_OK,       '0, '0, 0);
		add_row(OP_DELETE,   16'hFFFF, 32'h0,        0, ST_OK,       '0, '0, 0);
		add_row(OP_SEARCH,   16'hFFFF, 32'h0,        0, ST_OK,       '0, '0, 0);
		add_row(OP_POP,      16'h0,    32'h0,        0, ST_OK,       '0, '0, 0);
		add_row(OP_POP,      16'h0,    32'h0,        0, ST_OK,       '0, '0, 0);
		add_row(OP_POP,      16'h0,    32'h0,        0, ST_OK,       '0, '0, 0);
		add_row(OP_PUSH,     16'h0007, 32'h77,       0, ST_OK,       '0, '0, 0);
		add_row(OP_DELETE,   16'h0007, 32'h0,        0, ST_OK,       '0, '0, 0);

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i]);
		wait_for_results();

		// random segments: fill to full, drain to empty, or mixed traffic
		row = '0;
		while (random_sent < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			gappy = ($urandom_range(0, 2) != 0);
			foreach (segment_keys[j])
				segment_keys[j] = ($urandom_range(0, 4) == 0) ? KEY_W'($urandom_range(0, 3))
					: KEY_W'($urandom);
			if (kind < 2)
				seg_len = DEPTH - shadow_held + $urandom_range(1, 3);
			else if (kind == 2)
				seg_len = shadow_held + $urandom_range(1, 2);
			else
				seg_len = $urandom_range(8, 30);
			for (n = 0; n < seg_len && random_sent < RANDOM_ITEMS; n++) begin
				row.op = pick_operation(kind);
				row.key = pick_key();
				row.pay = pick_payload();
				send_item(row);
				random_sent++;
				if (random_sent == RANDOM_ITEMS / 2)
					wait_for_results();
				else if (gappy && random_sent < RANDOM_ITEMS - QUIET_TAIL &&
					$urandom_range(0, 3) == 0)
					pause_sender($urandom_range(1, 15));
			end
		end

		wait_for_results();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("%0d items taken, %0d results checked in %0d cycles", accepted_items,
			results_checked, cycle_count);
		$display("pushes refused when full: %0d, pops/peeks on empty: %0d, key misses: %0d",
			full_count, empty_count, miss_count);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/krs_pkg.sv
rtl/krs_ram.sv
rtl/keyed_record_stack.sv
tb/sv/testbench.sv
